>>> sv/slst_pkg.sv
// ============================================================================
// slst_pkg: shared types for the sorted list engine
// Item and result beats, operation and status codes, cell control word.
// ============================================================================
`default_nettype none

package slst_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_EVEN   = 2'd3
    } slst_action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } slst_status_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } slst_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [6:0] element_count;
        logic [6:0] even_count;
    } slst_rsp_t;

    // Control word broadcast to every cell of the row
    typedef struct packed {
        logic               cmp;
        logic               ins;
        logic               rem;
        logic signed [31:0] key;
    } slst_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } slst_state_t;

endpackage

`default_nettype wire

>>> sv/sorted_list_engine_unit.sv
// ============================================================================
// sorted_list_engine_unit: sorted store of signed 32-bit values
// Insert, remove, search and even-count over a row of shifting compare cells.
// ============================================================================
//
//  Channel  | Handshake           | Payload           | Direction
//  ---------+---------------------+-------------------+----------
//  command  | start / busy        | cmd   (slst_cmd_t) | in
//  response | done (one-cycle)    | result(slst_rsp_t) | out
//
//  Each item runs through three steps: accept, broadcast compare in every cell,
//  then shift the row and register the response beat. The compare stage and
//  the shift stage of the cell row are the CMP and APPLY states; the next item can be
//  accepted in the cycle where done is high.
//  Reset clears the counts and the control state; cell values are left as
//  they are, since only entries below the element count are ever looked at.
//  The receiver cannot stall: done is high for exactly one cycle per item.
//
`default_nettype none

module sorted_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire slst_pkg::slst_cmd_t cmd,
    output logic                     done,
    output slst_pkg::slst_rsp_t      result
);
    import slst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    slst_state_t        state_reg;
    slst_state_t        state_next;
    slst_cmd_t          op_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   even_reg;
    logic [CNT_W-1:0]   even_next;
    logic               done_reg;
    logic               done_next;
    slst_rsp_t          result_reg;
    slst_rsp_t          result_next;

    slst_ctl_t          ctl;
    logic               accept;
    logic               full;
    logic               hit_any;
    logic               is_even;

    logic signed [31:0] value_vec [CAPACITY];
    logic signed [31:0] left_value_w [CAPACITY];
    logic signed [31:0] right_value_w [CAPACITY];
    logic [CAPACITY-1:0] ge_vec;
    logic [CAPACITY-1:0] left_ge_w;
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] occ_vec;

    logic [CNT_W+6:0]   count_ext;
    logic [CNT_W+6:0]   even_ext;

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign full    = (count_reg == CAP_C);
    assign hit_any = |hit_vec;
    assign is_even = !op_reg.value[0];

    // ---------------------------------------------------------------------
    // Cell row: each cell talks only to its left and right neighbor
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_row
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        assign occ_vec[i] = (IDX < count_reg);

        if (i == 0)
        begin : g_head
            assign left_value_w[i] = '0;
            assign left_ge_w[i]    = 1'b0;
        end
        else
        begin : g_body
            assign left_value_w[i] = value_vec[i-1];
            assign left_ge_w[i]    = ge_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value_w[i] = '0;
        end
        else
        begin : g_mid
            assign right_value_w[i] = value_vec[i+1];
        end

        slst_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .occ         (occ_vec[i]),
            .left_value  (left_value_w[i]),
            .left_ge     (left_ge_w[i]),
            .right_value (right_value_w[i]),
            .value       (value_vec[i]),
            .ge          (ge_vec[i]),
            .hit         (hit_vec[i])
        );
    end

    // ---------------------------------------------------------------------
    // Row control: compare in CMP, shift in APPLY
    // ---------------------------------------------------------------------
    always_comb
    begin
        ctl.cmp = (state_reg == S_CMP);
        ctl.key = op_reg.value;
        // drop an insert into a full row; remove only on a match
        ctl.ins = (state_reg == S_APPLY) && (op_reg.action == ACT_INSERT) && !full;
        ctl.rem = (state_reg == S_APPLY) && (op_reg.action == ACT_REMOVE) && hit_any;
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = S_APPLY;
            S_APPLY: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Counts and response beat
    // ---------------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        even_next  = even_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + ONE_C;
            if (is_even)
            begin
                even_next = even_reg + ONE_C;
            end
        end
        else if (ctl.rem)
        begin
            count_next = count_reg - ONE_C;
            if (is_even)
            begin
                even_next = even_reg - ONE_C;
            end
        end
    end

    // counts wrap modulo 128 on the result fields
    assign count_ext = {7'd0, count_next};
    assign even_ext  = {7'd0, even_next};

    always_comb
    begin
        result_next.found         = 1'b0;
        result_next.status        = ST_OK;
        result_next.element_count = count_ext[6:0];
        result_next.even_count    = even_ext[6:0];
        unique case (op_reg.action) inside
            ACT_INSERT:
            begin
                if (full)
                begin
                    result_next.status = ST_FULL;
                end
            end
            ACT_REMOVE, ACT_SEARCH:
            begin
                if (count_reg == '0)
                begin
                    result_next.status = ST_EMPTY;
                end
                else if (hit_any)
                begin
                    result_next.found = 1'b1;
                end
                else
                begin
                    result_next.status = ST_MISSING;
                end
            end
            ACT_EVEN:
            begin
                if (count_reg == '0)
                begin
                    result_next.status = ST_EMPTY;
                end
            end
            default: result_next.status = ST_OK;
        endcase
    end

    assign done_next = (state_reg == S_APPLY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            even_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            even_reg  <= even_next;
            done_reg  <= done_next;
        end
    end

    // hold the item for the whole sequence; register the response beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= cmd;
        end
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> sv/slst_cell.sv
// ============================================================================
// slst_cell: one entry of the sorted row
// Holds one value, registers its compare flags and shifts with its neighbors.
// ============================================================================
`default_nettype none

module slst_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slst_pkg::slst_ctl_t ctl,
    input  wire logic               occ,
    input  wire logic signed [31:0] left_value,
    input  wire logic               left_ge,
    input  wire logic signed [31:0] right_value,
    output logic signed [31:0]      value,
    output logic                    ge,
    output logic                    hit
);
    import slst_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               ge_reg;
    logic               ge_next;
    logic               eq_reg;
    logic               eq_next;

    // Free entries count as "not below" so the insert point and shifts
    // run into them naturally.
    always_comb
    begin
        ge_next = ge_reg;
        eq_next = eq_reg;
        if (ctl.cmp)
        begin
            ge_next = !occ || (value_reg >= ctl.key);
            eq_next = occ && (value_reg == ctl.key);
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins && ge_reg)
        begin
            value_next = left_ge ? left_value : ctl.key;
        end
        else if (ctl.rem && ge_reg)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            ge_reg <= ge_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign ge    = ge_reg;
    // first entry not below the key, and equal to it
    assign hit   = eq_reg && !left_ge;

endmodule

`default_nettype wire

>>> sv/slst_checker.sv
// ============================================================================
// slst_checker: port-level checks for the sorted list engine
// Watches the command and response beats of the top level.
// ============================================================================
`default_nettype none

module slst_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire slst_pkg::slst_rsp_t result
);
    import slst_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("response beat missing three cycles after accept");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response beat while still busy");

    a_empty_counts: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_EMPTY) |->
            (result.element_count == 7'd0) && (result.even_count == 7'd0) && !result.found)
        else $error("empty status with nonzero counts or found");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.found |-> (result.status == ST_OK))
        else $error("found flag with non-ok status");

endmodule

bind sorted_list_engine_unit slst_checker u_slst_checker (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: sorted list engine testbench
// Sends insert, remove, search and even-count beats through start/busy,
// predicts each response with a queue kept in ascending order, and checks
// every field of each done beat against the oldest prediction.
// ============================================================================

module tb;
    import slst_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int IDLE_LIMIT = 2000;  // cycles with no beat before giving up
    localparam int DRAIN_WAIT = 8;     // cycles to wait past the last response

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    // Scoreboard: a sorted copy of the store plus the responses still owed
    class sorted_list_board;
        logic signed [31:0] entries[$];
        slst_rsp_t          awaited[$];
        int                 errors;
        int                 beats_seen;

        function new();
            errors     = 0;
            beats_seen = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // First slot whose value is not below v
        function int lower_slot(logic signed [31:0] v);
            int i;
            i = 0;
            while (i < entries.size() && entries[i] < v)
                i++;
            return i;
        endfunction

        function int even_total();
            int n;
            n = 0;
            foreach (entries[i])
                if (entries[i][0] == 1'b0)
                    n++;
            return n;
        endfunction

        function logic signed [31:0] any_stored();
            if (entries.size() == 0)
                return int'($urandom_range(16)) - 8;
            return entries[$urandom_range(entries.size() - 1)];
        endfunction

        // Apply one accepted command beat and queue the response it owes
        function void note_cmd(slst_cmd_t c);
            slst_rsp_t    r;
            slst_action_t act;
            int           pos;
            act      = slst_action_t'(c.action);
            r        = '0;
            r.status = ST_OK;
            if (act == ACT_INSERT)
            begin
                if (entries.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                    entries.insert(lower_slot(c.value), c.value);
            end
            else if (entries.size() == 0)
            begin
                r.status = ST_EMPTY;
            end
            else if (act != ACT_EVEN)
            begin
                pos = lower_slot(c.value);
                if (pos < entries.size() && entries[pos] == c.value)
                begin
                    r.found = 1'b1;
                    if (act == ACT_REMOVE)
                        entries.delete(pos);
                end
                else
                begin
                    r.status = ST_MISSING;
                end
            end
            r.element_count = 7'(entries.size());
            r.even_count    = 7'(even_total());
            awaited.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_rsp(slst_rsp_t got);
            slst_rsp_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("response beat with nothing expected (%p)", got));
                return;
            end
            want = awaited.pop_front();
            beats_seen++;
            if (got.status !== want.status)
                report($sformatf("beat %0d status got %0d want %0d",
                                 beats_seen, got.status, want.status));
            if (got.found !== want.found)
                report($sformatf("beat %0d found got %0d want %0d",
                                 beats_seen, got.found, want.found));
            if (got.element_count !== want.element_count)
                report($sformatf("beat %0d element_count got %0d want %0d",
                                 beats_seen, got.element_count, want.element_count));
            if (got.even_count !== want.even_count)
                report($sformatf("beat %0d even_count got %0d want %0d",
                                 beats_seen, got.even_count, want.even_count));
        endtask
    endclass

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    slst_cmd_t        cmd   = '0;
    logic             busy;
    logic             done;
    slst_rsp_t        result;
    sorted_list_board board = new();
    int               quiet_cycles = 0;
    int               idle_pct     = 0;  // chance, in percent, of a dead sender cycle

    sorted_list_engine_unit #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: sample both channels on the edge, before any driver update
    // lands. Note the command first so a same-edge response finds its slot.
    // The watchdog also lives here: it counts edges that move no beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_cmd(cmd);
            if (done)
                board.check_rsp(result);
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Send one command beat. Idle the sender first at the current rate,
    // scrambling the payload so the block must ignore it while start is low,
    // then hold start until the edge that takes the beat.
    task automatic send_beat(slst_action_t act, logic signed [31:0] v);
        slst_cmd_t c;
        c.action = act;
        c.value  = v;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            cmd   <= slst_cmd_t'({$urandom, $urandom});
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and hold off until every owed response has come back
    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly values already stored, so removes and searches hit; the rest are
    // a tight band around zero (duplicates), the two ends, and full noise.
    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return board.any_stored();
        if (roll < 80)
            return int'($urandom_range(16)) - 8;
        if (roll < 88)
        begin
            case ($urandom_range(3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return VAL_MAX - 1;
                default: return VAL_MIN + 1;
            endcase
        end
        return $urandom;
    endfunction

    // Random run with a given insert share; the rest split across remove,
    // search and even count. A high share fills the store and hits full,
    // a low one drains it and hits empty.
    task automatic random_run(int count, int insert_pct);
        int           k;
        int           roll;
        slst_action_t act;
        for (k = 0; k < count; k++)
        begin
            roll = $urandom_range(99);
            if (roll < insert_pct)
                act = ACT_INSERT;
            else
            begin
                roll = $urandom_range(99);
                if (roll < 50)
                    act = ACT_REMOVE;
                else if (roll < 85)
                    act = ACT_SEARCH;
                else
                    act = ACT_EVEN;
            end
            send_beat(act, pick_value());
        end
    endtask

    initial
    begin
        int pct_list[3];
        pct_list = '{0, 70, 9};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store first, then the ends of the value range,
        // a duplicate, removal of the tail and head, and a search above all
        send_beat(ACT_REMOVE, 5);
        send_beat(ACT_SEARCH, 5);
        send_beat(ACT_EVEN, 0);
        send_beat(ACT_INSERT, VAL_MAX);
        send_beat(ACT_INSERT, VAL_MIN);
        send_beat(ACT_INSERT, 0);
        send_beat(ACT_INSERT, -1);
        send_beat(ACT_INSERT, 0);
        send_beat(ACT_INSERT, 7);
        send_beat(ACT_EVEN, VAL_MAX);
        send_beat(ACT_SEARCH, 0);
        send_beat(ACT_SEARCH, 7);
        send_beat(ACT_SEARCH, 3);
        send_beat(ACT_REMOVE, VAL_MAX);
        send_beat(ACT_SEARCH, 100);
        send_beat(ACT_REMOVE, 100);
        send_beat(ACT_REMOVE, VAL_MIN);
        send_beat(ACT_REMOVE, 0);
        send_beat(ACT_REMOVE, 0);
        send_beat(ACT_SEARCH, 0);
        send_beat(ACT_REMOVE, -1);
        send_beat(ACT_REMOVE, 7);
        send_beat(ACT_EVEN, -1);
        send_beat(ACT_INSERT, -2);
        send_beat(ACT_REMOVE, -2);
        hold_until_drained();

        // Random: one fill and one drain run per sender idle rate, with a
        // full drain between phases so the block also restarts from quiet
        foreach (pct_list[p])
        begin
            idle_pct = pct_list[p];
            random_run(180, 75);
            random_run(150, 20);
            hold_until_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d responses never arrived", board.pending()));
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
sv/slst_pkg.sv
sv/slst_cell.sv
sv/sorted_list_engine_unit.sv
sv/slst_checker.sv
tb/tb.sv
